/* src/lgsp_pkg.sv */
// ----------------------------------------------------------------------------
// lgsp_pkg
// Shared types and constants for the label grid shape painter.
// ----------------------------------------------------------------------------
package lgsp_pkg;

  localparam int GRID      = 64;
  localparam int NUM_TYPES = 4;
  localparam int NREG      = 4;
  localparam int CELLS     = GRID * GRID;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(GRID);
  localparam int LABEL_W   = 3;
  localparam int SIDE_W    = 8;
  localparam int COORD_W   = 8;
  localparam int SUM_W     = SIDE_W + 1;
  localparam int POS_W     = 11;
  localparam int CFG_W     = 34;
  localparam int CFG_IDX_W = $clog2(NREG);
  localparam int COLOR_W   = 8;

  // config word layout
  localparam int SHAPE_LSB = 32;
  localparam int SIDE_LSB  = 24;
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;

  localparam logic [1:0] SHAPE_SQUARE  = 2'd1;
  localparam logic [1:0] SHAPE_DIAMOND = 2'd2;

  typedef logic [CFG_W-1:0] cfg_word_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_EMPTY  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_RESULT
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic [LABEL_W-1:0]  type_index;
  } item_t;

  typedef struct packed {
    stat_t               status;
    logic [LABEL_W-1:0]  cell_label;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } result_t;

endpackage

/* src/lgsp_grid_ram.sv */
// ----------------------------------------------------------------------------
// lgsp_grid_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lgsp_grid_ram #(
  parameter int DEPTH  = 4096,
  parameter int DATA_W = 3,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/lgsp_painter.sv */
// ----------------------------------------------------------------------------
// lgsp_painter
// Sequencer that clears, paints and reads the label grid memory.
// ----------------------------------------------------------------------------
module lgsp_painter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              item_valid_i,
  output logic                              item_ready_o,
  input  lgsp_pkg::item_t                   item_i,
  input  lgsp_pkg::cfg_word_t               type_word_i [lgsp_pkg::NREG],
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output lgsp_pkg::result_t                 res_o
);
  import lgsp_pkg::*;

  state_t               state_r, state_nxt;
  logic [ADDR_W-1:0]    cnt_r, cnt_nxt;
  logic [SIDE_W-1:0]    row_r, row_nxt;
  logic [SIDE_W-1:0]    col_r, col_nxt;
  logic [SIDE_W-1:0]    side_r, side_nxt;
  logic [1:0]           shape_r, shape_nxt;
  logic [LABEL_W-1:0]   lab_r, lab_nxt;
  logic [ROW_W-1:0]     x0_r, x0_nxt;
  logic [ROW_W-1:0]     y0_r, y0_nxt;
  result_t              res_r, res_nxt;

  // memory port
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [LABEL_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [LABEL_W-1:0]   mem_rdata;

  // item decode
  logic                 accept;
  logic [LABEL_W-1:0]   tm1;
  cfg_word_t            in_word;
  logic [1:0]           in_shape;
  logic [SIDE_W-1:0]    in_side;
  logic                 type_ok, shape_ok, fits_ok, rd_ok;
  logic signed [POS_W-1:0] xw, yw, hi_w, lo_w, sw, grid_s;

  // draw walk
  logic [ROW_W-1:0]     cur_x, cur_y;
  logic [ADDR_W-1:0]    draw_addr;
  logic signed [POS_W-1:0] r_s, c_s, s_s, h_s, k_s, two_r, even2;
  logic                 diam_hit, paint_hit, row_end, draw_end, sweep_end;

  // read lookup
  logic [LABEL_W-1:0]   lm1;
  cfg_word_t            rd_word;

  lgsp_grid_ram #(
    .DEPTH  (CELLS),
    .DATA_W (LABEL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- decode
  assign accept   = item_valid_i && item_ready_o;
  assign tm1      = item_i.type_index - LABEL_W'(1);
  assign in_word  = type_word_i[tm1[CFG_IDX_W-1:0]];
  assign in_shape = in_word[SHAPE_LSB +: 2];
  assign in_side  = in_word[SIDE_LSB +: SIDE_W];

  assign type_ok  = (item_i.type_index != '0) && (int'(item_i.type_index) <= NUM_TYPES)
                    && (int'(item_i.type_index) <= NREG);
  assign shape_ok = (in_shape == SHAPE_SQUARE) || (in_shape == SHAPE_DIAMOND);

  assign grid_s   = POS_W'(GRID);
  assign xw       = POS_W'($signed(item_i.x_pos));
  assign yw       = POS_W'($signed(item_i.y_pos));
  assign hi_w     = (xw > yw) ? xw : yw;
  assign lo_w     = (xw < yw) ? xw : yw;
  assign sw       = POS_W'({1'b0, in_side});
  assign fits_ok  = (hi_w + sw < grid_s) && (lo_w >= 0) && (in_side != '0);
  assign rd_ok    = (xw >= 0) && (yw >= 0) && (xw < grid_s) && (yw < grid_s);

  // ---------------------------------------------------------------- draw walk
  assign cur_x     = ROW_W'(SUM_W'(x0_r) + SUM_W'(col_r));
  assign cur_y     = ROW_W'(SUM_W'(y0_r) + SUM_W'(row_r));
  assign draw_addr = ADDR_W'(cur_y) * ADDR_W'(GRID) + ADDR_W'(cur_x);

  assign r_s   = POS_W'({1'b0, row_r});
  assign c_s   = POS_W'({1'b0, col_r});
  assign s_s   = POS_W'({1'b0, side_r});
  assign h_s   = POS_W'({1'b0, (side_r - SIDE_W'(1)) >> 1});
  assign two_r = r_s <<< 1;
  assign even2 = POS_W'({1'b0, side_r[SIDE_W-1:1], 1'b0});
  // rows widen up to the middle, then narrow again
  assign k_s   = (two_r < s_s - POS_W'(1)) ? r_s : even2 - r_s;
  assign diam_hit  = (c_s > h_s - k_s) && (c_s < s_s - POS_W'(1) - h_s + k_s);
  assign paint_hit = (shape_r == SHAPE_SQUARE) || diam_hit;

  assign row_end   = (col_r == side_r - SIDE_W'(1));
  assign draw_end  = row_end && (row_r == side_r - SIDE_W'(1));
  assign sweep_end = (cnt_r == ADDR_W'(CELLS - 1));

  // ---------------------------------------------------------------- read lookup
  assign lm1     = mem_rdata - LABEL_W'(1);
  assign rd_word = type_word_i[lm1[CFG_IDX_W-1:0]];

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sweep_end) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          case (item_i.op)
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_DRAW:  state_nxt = (type_ok && shape_ok && fits_ok) ? S_DRAW : S_RESULT;
            OP_READ:  state_nxt = rd_ok ? S_READ : S_RESULT;
            default:  state_nxt = S_RESULT;
          endcase
        end
      end
      S_CLEAR: begin
        if (sweep_end) state_nxt = S_RESULT;
      end
      S_DRAW: begin
        if (draw_end) state_nxt = S_RESULT;
      end
      S_READ: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (res_ready_i) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = ADDR_W'(item_i.y_pos[ROW_W-1:0]) * ADDR_W'(GRID)
                   + ADDR_W'(item_i.x_pos[ROW_W-1:0]);
    case (state_r)
      S_INIT, S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        item_ready_o = 1'b1;
        mem_re       = item_valid_i && (item_i.op == OP_READ) && rd_ok;
      end
      S_DRAW: begin
        mem_we    = paint_hit;
        mem_waddr = draw_addr;
        mem_wdata = lab_r;
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o = res_r;

  // ---------------------------------------------------------------- datapath
  always_comb begin
    cnt_nxt   = cnt_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    side_nxt  = side_r;
    shape_nxt = shape_r;
    lab_nxt   = lab_r;
    x0_nxt    = x0_r;
    y0_nxt    = y0_r;
    res_nxt   = res_r;
    case (state_r)
      S_INIT, S_CLEAR: begin
        cnt_nxt = cnt_r + ADDR_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          cnt_nxt   = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          side_nxt  = in_side;
          shape_nxt = in_shape;
          lab_nxt   = item_i.type_index;
          x0_nxt    = item_i.x_pos[ROW_W-1:0];
          y0_nxt    = item_i.y_pos[ROW_W-1:0];
          if (item_i.op == OP_DRAW) begin
            if (!type_ok || !shape_ok) res_nxt.status = STAT_EMPTY;
            else if (!fits_ok)         res_nxt.status = STAT_BOUNDS;
          end else if (item_i.op == OP_READ && !rd_ok) begin
            res_nxt.status = STAT_BOUNDS;
          end
        end
      end
      S_DRAW: begin
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + SIDE_W'(1);
        end else begin
          col_nxt = col_r + SIDE_W'(1);
        end
      end
      S_READ: begin
        res_nxt.cell_label = mem_rdata;
        if (mem_rdata != '0 && int'(mem_rdata) <= NREG) begin
          res_nxt.red   = rd_word[RED_LSB +: COLOR_W];
          res_nxt.green = rd_word[GREEN_LSB +: COLOR_W];
          res_nxt.blue  = rd_word[BLUE_LSB +: COLOR_W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    side_r  <= side_nxt;
    shape_r <= shape_nxt;
    lab_r   <= lab_nxt;
    x0_r    <= x0_nxt;
    y0_r    <= y0_nxt;
    res_r   <= res_nxt;
  end

`ifndef NO_ASSERTIONS
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_INIT || state_r == S_CLEAR || state_r == S_DRAW))
    else $error("grid write outside a sweep or draw");

  a_draw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAW) |-> (row_r < side_r && col_r < side_r))
    else $error("draw walk left the shape box");

  a_read_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ($past(state_r) == S_IDLE && $past(mem_re)))
    else $error("read state without a memory read");

  a_result_leave: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && res_ready_i) |=> (state_r == S_IDLE))
    else $error("result handed over but sequencer not idle");
`endif

endmodule

/* src/label_grid_shape_painter.sv */
// ----------------------------------------------------------------------------
// label_grid_shape_painter
// Label grid with clear, shape draw and cell read items; type words set
// shape, side and colour.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tuser op; tdata x_pos, y_pos, type_index
//  out_    | out | out_tvalid/out_tready| tuser status; tdata label, red, green, blue
//  cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// A draw walks its shape box one grid cell per cycle through the single RAM
// write port; a clear sweeps every grid cell through the same port.
// After reset a zeroing sweep writes all CELLS (4096) cells; in_tready stays low.
// Results go to an output register, so a new item is taken while the previous
// result waits; the sequencer stalls only when that register is still full.
// ----------------------------------------------------------------------------
module label_grid_shape_painter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // x_pos, y_pos, type_index
  input  logic [1:0]                      in_tuser,   // op
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,  // cell_label, red, green, blue
  output logic [1:0]                      out_tuser,  // status
  input  logic                            cfg_we,
  input  logic [lgsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lgsp_pkg::CFG_W-1:0]      cfg_wdata
);
  import lgsp_pkg::*;

  cfg_word_t  type_word_r [NREG];
  item_t      item;
  result_t    res;
  logic       res_valid, res_ready;
  logic       out_valid_r;
  result_t    out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NREG; i++) begin
        type_word_r[i] <= '0;
      end
    end else if (cfg_we) begin
      type_word_r[cfg_index] <= cfg_wdata;
    end
  end

  assign item.op         = op_t'(in_tuser);
  assign item.x_pos      = in_tdata[7:0];
  assign item.y_pos      = in_tdata[15:8];
  assign item.type_index = in_tdata[18:16];

  lgsp_painter u_painter (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid_i (in_tvalid),
    .item_ready_o (in_tready),
    .item_i       (item),
    .type_word_i  (type_word_r),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {5'b0, out_res_r.blue, out_res_r.green, out_res_r.red,
                       out_res_r.cell_label};

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb - label grid shape painter testbench
// Drives clear, draw and read items over the input stream and programs the
// four type words between phases. Each result, from a local grid model or a
// directed row, is checked field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import lgsp_pkg::*;

  localparam int STALL_LIMIT  = 40000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 47;

  typedef struct {
    op_t        op;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] t;
    bit         typed;
    result_t    res;
  } dir_row_t;

  typedef struct {
    bit      typed;
    result_t res;
  } typed_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // grid and type word model
  logic [LABEL_W-1:0] grid_model [CELLS];
  cfg_word_t type_model [NREG];

  result_t pending_results [$];
  typed_res_t typed_q [$];
  dir_row_t dir_rows [$];

  int n_items = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_painted = 0;
  int n_label_reads = 0;
  int n_clears = 0;
  int n_cfg_sets = 0;
  int snd_idle_pct = 34;
  int rcv_idle_pct = 82;
  int idle_cycles = 0;
  int last_x = 0;
  int last_y = 0;
  int last_s = 0;

  always #5 clk = ~clk;

  label_grid_shape_painter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic result_t make_result(stat_t st, logic [2:0] lab, logic [23:0] rgb);
    result_t res;
    res.status     = st;
    res.cell_label = lab;
    res.red        = rgb[23:16];
    res.green      = rgb[15:8];
    res.blue       = rgb[7:0];
    return res;
  endfunction

  // applies one item to the grid model and returns its result
  function automatic result_t grid_response(op_t op, logic signed [7:0] xs,
                                            logic signed [7:0] ys, logic [2:0] t);
    result_t res;
    cfg_word_t w;
    logic [1:0] shape;
    logic [2:0] lab;
    int x, y, s, h, k, hi, lo;
    res = make_result(STAT_DONE, '0, '0);
    x = xs;
    y = ys;
    case (op)
      OP_CLEAR: begin
        foreach (grid_model[i]) grid_model[i] = '0;
        n_clears++;
      end
      OP_DRAW: begin
        if (t == 0 || t > NUM_TYPES) begin
          res.status = STAT_EMPTY;
        end else begin
          w = type_model[t-1];
          shape = w[SHAPE_LSB +: 2];
          s = w[SIDE_LSB +: SIDE_W];
          hi = (x > y) ? x : y;
          lo = (x < y) ? x : y;
          if (shape != SHAPE_SQUARE && shape != SHAPE_DIAMOND) begin
            res.status = STAT_EMPTY;
          end else if (hi + s >= GRID || lo < 0 || s == 0) begin
            res.status = STAT_BOUNDS;
          end else begin
            h = (s - 1) / 2;
            for (int r = 0; r < s; r++) begin
              // diamond half width grows to the middle row, then shrinks
              k = (2 * r < s - 1) ? r : 2 * (s / 2) - r;
              for (int c = 0; c < s; c++) begin
                if (shape == SHAPE_SQUARE || (c > h - k && c < s - 1 - h + k))
                  grid_model[(y + r) * GRID + x + c] = t;
              end
            end
            n_painted++;
          end
        end
      end
      OP_READ: begin
        if (x < 0 || y < 0 || x >= GRID || y >= GRID) begin
          res.status = STAT_BOUNDS;
        end else begin
          lab = grid_model[y * GRID + x];
          res.cell_label = lab;
          if (lab != 0 && lab <= NREG) begin
            w = type_model[lab-1];
            res.red   = w[RED_LSB +: COLOR_W];
            res.green = w[GREEN_LSB +: COLOR_W];
            res.blue  = w[BLUE_LSB +: COLOR_W];
            n_label_reads++;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic cfg_word_t rand_type_word();
    logic [1:0] shape;
    logic [7:0] side;
    logic [23:0] rgb;
    int pick;
    pick = $urandom_range(9);
    shape = (pick < 4) ? SHAPE_SQUARE : (pick < 8) ? SHAPE_DIAMOND :
            (pick == 8) ? 2'd0 : 2'd3;
    pick = $urandom_range(19);
    if (pick == 0)      side = 8'd0;
    else if (pick == 1) side = 8'($urandom_range(255));
    else if (pick == 2) side = 8'($urandom_range(40, 63));
    else                side = 8'($urandom_range(1, 10));
    pick = $urandom_range(9);
    rgb = (pick == 0) ? 24'h000000 : (pick == 1) ? 24'hFFFFFF : 24'($urandom);
    return {shape, side, rgb};
  endfunction

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_errors++;
    end
  endtask

  task automatic send_item(op_t op, logic [7:0] x, logic [7:0] y, logic [2:0] t);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'd0, t, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (n_results < n_items) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_type_words(cfg_word_t w0, cfg_word_t w1, cfg_word_t w2,
                                 cfg_word_t w3);
    cfg_word_t words [NREG];
    words[0] = w0;
    words[1] = w1;
    words[2] = w2;
    words[3] = w3;
    for (int i = 0; i < NREG; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= words[i];
      @(posedge clk);
      type_model[i] = words[i];
    end
    cfg_we <= 1'b0;
    n_cfg_sets++;
  endtask

  task automatic add_row(op_t op, logic [7:0] x, logic [7:0] y, logic [2:0] t,
                         bit typed, stat_t st, logic [2:0] lab, logic [23:0] rgb);
    dir_row_t row;
    row.op = op;
    row.x = x;
    row.y = y;
    row.t = t;
    row.typed = typed;
    row.res = make_result(st, lab, rgb);
    dir_rows.push_back(row);
  endtask

  task automatic send_random_item();
    int kind, t, s, x, y;
    kind = $urandom_range(99);
    if (kind < 2) begin
      send_item(OP_CLEAR, 8'($urandom), 8'($urandom), 3'($urandom));
    end else if (kind < 47) begin
      // draw, placed to fit the grid when the chosen type has a side of 1 to GRID-1
      t = $urandom_range(1, NUM_TYPES);
      s = type_model[t-1][SIDE_LSB +: SIDE_W];
      if (s > 0 && s < GRID) begin
        x = $urandom_range(GRID - 1 - s);
        y = $urandom_range(GRID - 1 - s);
      end else begin
        x = $urandom_range(GRID - 1);
        y = $urandom_range(GRID - 1);
      end
      last_x = x;
      last_y = y;
      last_s = s;
      send_item(OP_DRAW, 8'(x), 8'(y), 3'(t));
    end else if (kind < 85) begin
      // read, mostly inside the latest drawn area
      if (kind < 75 && last_s > 0 && last_s < GRID) begin
        x = last_x + $urandom_range(last_s);
        y = last_y + $urandom_range(last_s);
        if (x > GRID - 1) x = GRID - 1;
        if (y > GRID - 1) y = GRID - 1;
      end else begin
        x = $urandom_range(GRID - 1);
        y = $urandom_range(GRID - 1);
      end
      send_item(OP_READ, 8'(x), 8'(y), 3'($urandom));
    end else begin
      send_item(op_t'($urandom_range(3)), 8'($urandom), 8'($urandom), 3'($urandom));
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // predict on input accept, compare on output accept
  always @(posedge clk) begin : monitor
    result_t exp_res;
    typed_res_t tr;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_res = grid_response(op_t'(in_tuser), in_tdata[7:0], in_tdata[15:8],
                                in_tdata[18:16]);
        if (typed_q.size() != 0) begin
          tr = typed_q.pop_front();
          if (tr.typed) exp_res = tr.res;
        end
        pending_results.push_back(exp_res);
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with no item pending: status %0d tdata %h", out_tuser, out_tdata);
          n_errors++;
        end else begin
          exp_res = pending_results.pop_front();
          check_field("status", 8'(exp_res.status), 8'(out_tuser));
          check_field("cell_label", 8'(exp_res.cell_label), 8'(out_tdata[2:0]));
          check_field("red", exp_res.red, out_tdata[10:3]);
          check_field("green", exp_res.green, out_tdata[18:11]);
          check_field("blue", exp_res.blue, out_tdata[26:19]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    typed_res_t tr;
    foreach (grid_model[i]) grid_model[i] = '0;
    foreach (type_model[i]) type_model[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: square side 4, diamond side 5, shape code 3, side zero
    load_type_words({SHAPE_SQUARE, 8'd4, 24'hFFFFFF}, {SHAPE_DIAMOND, 8'd5, 24'h123456},
                    {2'd3, 8'd2, 24'hABCDEF}, {SHAPE_SQUARE, 8'd0, 24'h00FF00});
    add_row(OP_READ,  8'h00, 8'h00, 3'd0, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h80, 8'h80, 3'd0, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_READ,  8'h7F, 8'h7F, 3'd7, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_READ,  8'h40, 8'h00, 3'd0, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_READ,  8'h00, 8'hFF, 3'd0, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_READ,  8'h3F, 8'h3F, 3'd0, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h00, 3'd0, 1, STAT_EMPTY,  3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h00, 3'd5, 1, STAT_EMPTY,  3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h00, 3'd7, 1, STAT_EMPTY,  3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h00, 3'd3, 1, STAT_EMPTY,  3'd0, 24'h0);
    add_row(OP_DRAW,  8'h0A, 8'h0A, 3'd4, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_DRAW,  8'hFF, 8'h00, 3'd1, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_DRAW,  8'h3C, 8'h00, 3'd1, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h80, 3'd1, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_DRAW,  8'h7F, 8'h00, 3'd1, 1, STAT_BOUNDS, 3'd0, 24'h0);
    add_row(OP_DRAW,  8'h3B, 8'h3B, 3'd1, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h3E, 8'h3E, 3'd0, 1, STAT_DONE,   3'd1, 24'hFFFFFF);
    add_row(OP_READ,  8'h3A, 8'h3A, 3'd0, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_DRAW,  8'h00, 8'h00, 3'd2, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h02, 8'h02, 3'd0, 0, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h00, 8'h02, 3'd0, 0, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h02, 8'h00, 3'd0, 0, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_NONE,  8'hFF, 8'hFF, 3'd7, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_CLEAR, 8'h00, 8'h00, 3'd0, 1, STAT_DONE,   3'd0, 24'h0);
    add_row(OP_READ,  8'h3E, 8'h3E, 3'd0, 1, STAT_DONE,   3'd0, 24'h0);
    foreach (dir_rows[i]) begin
      tr.typed = dir_rows[i].typed;
      tr.res = dir_rows[i].res;
      typed_q.push_back(tr);
      send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].t);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES / 3) begin
        snd_idle_pct = 82;
        rcv_idle_pct = 34;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      wait_idle();
      if (ph == 0)
        load_type_words({SHAPE_SQUARE, 8'd63, 24'hFFFFFF}, {SHAPE_DIAMOND, 8'd63, 24'h000000},
                        {2'd0, 8'd255, 24'h5A5A5A}, {SHAPE_DIAMOND, 8'd62, 24'hA5C3E1});
      else if (ph == 1)
        load_type_words({SHAPE_SQUARE, 8'd1, 24'h000001}, {SHAPE_DIAMOND, 8'd1, 24'h800000},
                        {SHAPE_DIAMOND, 8'd2, 24'h008000}, {2'd3, 8'd255, 24'hFFFFFF});
      else
        load_type_words(rand_type_word(), rand_type_word(), rand_type_word(),
                        rand_type_word());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then hold off until the block has drained
        if ($urandom_range(99) < 3) wait_idle();
        send_random_item();
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end
    $display("run: %0d items, %0d results, %0d type word sets, %0d clears",
             n_items, n_results, n_cfg_sets, n_clears);
    $display("run: %0d shapes painted, %0d reads of painted cells, %0d errors",
             n_painted, n_label_reads, n_errors);
    if (n_errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
